// ----- rtl/vrfi_pkg.sv -----
// Shared types and register constants of the video register file and interrupt unit.
package vrfi_pkg;

   // Item kinds
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_LINE  = 2'd2,
      OP_HIT   = 2'd3
   } op_type;

   // Register indexes
   localparam logic [5:0] REG_CTRL1       = 6'h11;
   localparam logic [5:0] REG_RASTER      = 6'h12;
   localparam logic [5:0] REG_CTRL2       = 6'h16;
   localparam logic [5:0] REG_MEM_PTR     = 6'h18;
   localparam logic [5:0] REG_IRQ_FLAG    = 6'h19;
   localparam logic [5:0] REG_IRQ_MASK    = 6'h1A;
   localparam logic [5:0] REG_SP_SP_HIT   = 6'h1E;
   localparam logic [5:0] REG_SP_BG_HIT   = 6'h1F;
   localparam logic [5:0] REG_BORDER      = 6'h20;
   localparam logic [5:0] REG_BG_COLOR0   = 6'h21;
   localparam logic [5:0] REG_UNUSED_LOW  = 6'h2F;

   // Reset contents of the color registers
   localparam logic [7:0] BORDER_RESET    = 8'd14;
   localparam logic [7:0] BG_COLOR0_RESET = 8'd6;

   // Interrupt sources and flag bits
   localparam logic [7:0] SRC_RASTER  = 8'h01;
   localparam logic [7:0] SRC_BG_HIT  = 8'h02;
   localparam logic [7:0] SRC_SP_HIT  = 8'h04;
   localparam logic [7:0] IRQ_ANY     = 8'h80;
   localparam logic [7:0] FLAG_FILL   = 8'h70;
   localparam logic [7:0] NIBBLE_FILL = 8'hF0;
   localparam logic [7:0] CTRL2_FILL  = 8'hC0;
   localparam logic [7:0] MEMPTR_FILL = 8'h01;
   localparam logic [7:0] OPEN_BUS    = 8'hFF;

   // Character ROM windows
   localparam logic [15:0] CHAR_ROM_LO = 16'hD000;
   localparam logic [15:0] CHAR_ROM_HI = 16'hD800;

endpackage

// ----- rtl/video_register_file_irq.sv -----
// Register file, raster compare and interrupt logic of a raster video chip.
// Path: each item passes the input stage, then the result register; either can stall.
// One item per cycle unless rsp_ready stalls; memory read at transfer plus one write port.
// Reset: synchronous; register contents are zero with 20h = 14 and 21h = 6 through
// per-entry valid bits, raster line, bank select and interrupt state cleared; no clearing pass.
module video_register_file_irq
   import vrfi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [5:0]  req_reg_addr,
   input  logic [7:0]  req_write_data,
   input  logic [8:0]  req_raster_line,
   input  logic [7:0]  req_sprite_sprite_hits,
   input  logic [7:0]  req_sprite_background_hits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq_out,
   output logic [15:0] rsp_matrix_addr,
   output logic [15:0] rsp_charset_addr,
   output logic        rsp_charset_in_rom
);

   // Plain registers live in memory; the ones with side effects live in flops
   logic [7:0]  gen_mem [64];
   logic [63:0] mem_vld_ff;

   logic        req_xfer;
   logic        s1_go;
   logic        mem_we;
   logic [7:0]  mem_wdata;
   logic        byp;

   logic        s1_valid_ff;
   op_type      s1_op_ff;
   logic [5:0]  s1_addr_ff;
   logic [7:0]  s1_wdata_ff;
   logic [8:0]  s1_line_ff;
   logic [7:0]  s1_ss_ff;
   logic [7:0]  s1_sb_ff;
   logic [7:0]  s1_mem_ff;
   logic        s1_memok_ff;
   logic        s1_byp_ff;
   logic [7:0]  s1_byp_data_ff;

   logic [7:0]  reg11_ff, reg11_in;
   logic [7:0]  reg12_ff, reg12_in;
   logic [7:0]  reg18_ff, reg18_in;
   logic [7:0]  reg19_ff, reg19_in;
   logic [7:0]  reg1a_ff, reg1a_in;
   logic [7:0]  reg1e_ff, reg1e_in;
   logic [7:0]  reg1f_ff, reg1f_in;
   logic [8:0]  line_ff, line_in;
   logic [1:0]  bank_ff;

   logic [7:0]  rd_in;
   logic [15:0] caddr_in;
   logic        rom_in;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_rd_ff;
   logic        rsp_irq_ff;
   logic [15:0] rsp_maddr_ff;
   logic [15:0] rsp_caddr_ff;
   logic        rsp_rom_ff;

   // Handshake: the input stage moves on whenever the result register is free
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_xfer  = req_valid && req_ready;

   // Plain register writes go to memory
   assign mem_we = s1_go && (s1_op_ff == OP_WRITE) &&
                   (s1_addr_ff != REG_CTRL1)     && (s1_addr_ff != REG_RASTER)   &&
                   (s1_addr_ff != REG_MEM_PTR)   && (s1_addr_ff != REG_IRQ_FLAG) &&
                   (s1_addr_ff != REG_IRQ_MASK)  && (s1_addr_ff != REG_SP_SP_HIT) &&
                   (s1_addr_ff != REG_SP_BG_HIT);
   assign mem_wdata = (s1_addr_ff == REG_CTRL2) ? (s1_wdata_ff | CTRL2_FILL) : s1_wdata_ff;
   assign byp       = mem_we && (s1_addr_ff == req_reg_addr);

   // Bank select
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 2'd0;
      end else if (csr_wr_en) begin
         bank_ff <= csr_wr_data;
      end
   end

   // Memory write port and valid bits
   always_ff @(posedge clock) begin
      if (mem_we) begin
         gen_mem[s1_addr_ff] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_vld_ff <= '0;
      end else if (mem_we) begin
         mem_vld_ff[s1_addr_ff] <= 1'b1;
      end
   end

   // Memory read port, registered at transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_mem_ff <= gen_mem[req_reg_addr];
      end
   end

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff       <= op_type'(req_opcode);
         s1_addr_ff     <= req_reg_addr;
         s1_wdata_ff    <= req_write_data;
         s1_line_ff     <= req_raster_line;
         s1_ss_ff       <= req_sprite_sprite_hits;
         s1_sb_ff       <= req_sprite_background_hits;
         s1_memok_ff    <= mem_vld_ff[req_reg_addr];
         s1_byp_ff      <= byp;
         s1_byp_data_ff <= mem_wdata;
      end
   end

   // Execute one item against the register state
   always_comb begin
      logic [7:0] gen_val;
      logic [7:0] src;
      logic [7:0] flag_tmp;

      reg11_in = reg11_ff;
      reg12_in = reg12_ff;
      reg18_in = reg18_ff;
      reg19_in = reg19_ff;
      reg1a_in = reg1a_ff;
      reg1e_in = reg1e_ff;
      reg1f_in = reg1f_ff;
      line_in  = line_ff;
      rd_in    = 8'h00;
      src      = 8'h00;
      flag_tmp = 8'h00;

      // Unwritten entries read their reset contents
      if (s1_byp_ff) begin
         gen_val = s1_byp_data_ff;
      end else if (s1_memok_ff) begin
         gen_val = s1_mem_ff;
      end else if (s1_addr_ff == REG_BORDER) begin
         gen_val = BORDER_RESET;
      end else if (s1_addr_ff == REG_BG_COLOR0) begin
         gen_val = BG_COLOR0_RESET;
      end else begin
         gen_val = 8'h00;
      end

      case (s1_op_ff)
         OP_READ: begin
            unique case (s1_addr_ff)
               REG_CTRL1:     rd_in = {line_ff[8], reg11_ff[6:0]};
               REG_RASTER:    rd_in = line_ff[7:0];
               REG_MEM_PTR:   rd_in = reg18_ff;
               REG_IRQ_FLAG:  rd_in = reg19_ff | FLAG_FILL;
               REG_IRQ_MASK:  rd_in = reg1a_ff | NIBBLE_FILL;
               REG_SP_SP_HIT: begin
                  rd_in    = reg1e_ff;
                  reg1e_in = 8'h00;
               end
               REG_SP_BG_HIT: begin
                  rd_in    = reg1f_ff;
                  reg1f_in = 8'h00;
               end
               default: begin
                  if (s1_addr_ff >= REG_UNUSED_LOW) begin
                     rd_in = OPEN_BUS;
                  end else if (s1_addr_ff >= REG_BORDER) begin
                     rd_in = gen_val | NIBBLE_FILL;
                  end else begin
                     rd_in = gen_val;
                  end
               end
            endcase
         end
         OP_WRITE: begin
            unique case (s1_addr_ff)
               REG_CTRL1: begin
                  reg11_in = s1_wdata_ff;
                  if ((reg11_ff[7] != s1_wdata_ff[7]) &&
                      (line_ff == {s1_wdata_ff[7], reg12_ff})) begin
                     src = SRC_RASTER;
                  end
               end
               REG_RASTER: begin
                  reg12_in = s1_wdata_ff;
                  if ((reg12_ff != s1_wdata_ff) &&
                      (line_ff == {reg11_ff[7], s1_wdata_ff})) begin
                     src = SRC_RASTER;
                  end
               end
               REG_MEM_PTR: reg18_in = s1_wdata_ff | MEMPTR_FILL;
               REG_IRQ_FLAG: begin
                  // Acknowledge flags written as one, then recompute the summary bit
                  flag_tmp = reg19_ff & {4'h0, ~s1_wdata_ff[3:0]};
                  reg19_in = ((flag_tmp & reg1a_ff) != 8'h00) ? (flag_tmp | IRQ_ANY)
                                                               : flag_tmp;
               end
               REG_IRQ_MASK: begin
                  reg1a_in = {4'h0, s1_wdata_ff[3:0]};
                  reg19_in = {(reg19_ff[3:0] & s1_wdata_ff[3:0]) != 4'h0, reg19_ff[6:0]};
               end
               default: begin
               end
            endcase
         end
         OP_LINE: begin
            line_in = s1_line_ff;
            if (s1_line_ff == {reg11_ff[7], reg12_ff}) begin
               src = SRC_RASTER;
            end
         end
         default: begin
            reg1e_in = reg1e_ff | s1_ss_ff;
            reg1f_in = reg1f_ff | s1_sb_ff;
            src = ((s1_ss_ff != 8'h00) ? SRC_SP_HIT : 8'h00) |
                  ((s1_sb_ff != 8'h00) ? SRC_BG_HIT : 8'h00);
         end
      endcase

      // Raise interrupt sources
      if ((reg1a_in & src) != 8'h00) begin
         reg19_in = reg19_in | src | IRQ_ANY;
      end else begin
         reg19_in = reg19_in | src;
      end
   end

   // Decode the charset address, with the ROM window in banks 0 and 2
   always_comb begin
      caddr_in = {bank_ff, reg18_in[3:1], 11'h000};
      rom_in   = 1'b0;
      if (!bank_ff[0]) begin
         if (reg18_in[3:1] == 3'b010) begin
            caddr_in = CHAR_ROM_LO;
            rom_in   = 1'b1;
         end else if (reg18_in[3:1] == 3'b011) begin
            caddr_in = CHAR_ROM_HI;
            rom_in   = 1'b1;
         end
      end
   end

   // Commit register state
   always_ff @(posedge clock) begin
      if (reset) begin
         reg11_ff <= 8'h00;
         reg12_ff <= 8'h00;
         reg18_ff <= 8'h00;
         reg19_ff <= 8'h00;
         reg1a_ff <= 8'h00;
         reg1e_ff <= 8'h00;
         reg1f_ff <= 8'h00;
         line_ff  <= 9'h000;
      end else if (s1_go) begin
         reg11_ff <= reg11_in;
         reg12_ff <= reg12_in;
         reg18_ff <= reg18_in;
         reg19_ff <= reg19_in;
         reg1a_ff <= reg1a_in;
         reg1e_ff <= reg1e_in;
         reg1f_ff <= reg1f_in;
         line_ff  <= line_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         rsp_rd_ff    <= rd_in;
         rsp_irq_ff   <= reg19_in[7];
         rsp_maddr_ff <= {bank_ff, reg18_in[7:4], 10'h000};
         rsp_caddr_ff <= caddr_in;
         rsp_rom_ff   <= rom_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_rd_ff;
   assign rsp_irq_out        = rsp_irq_ff;
   assign rsp_matrix_addr    = rsp_maddr_ff;
   assign rsp_charset_addr   = rsp_caddr_ff;
   assign rsp_charset_in_rom = rsp_rom_ff;

   // Interrupt line in a loaded result matches the committed flag register
   a_irq_follows_flag: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> (rsp_irq_out == reg19_ff[7]))
      else $error("irq output does not follow flag register bit 7");

   // Unused flag and mask bits never set
   a_flag_mask_clean: assert property (@(posedge clock) disable iff (reset)
      (reg19_ff[6:4] == 3'b000) && (reg1a_ff[7:4] == 4'h0))
      else $error("unused interrupt flag or mask bits set");

   // ROM charset only ever maps to the ROM windows
   a_rom_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_charset_in_rom) |->
         ((rsp_charset_addr == CHAR_ROM_LO) || (rsp_charset_addr == CHAR_ROM_HI)))
      else $error("charset in ROM outside the ROM window");

   // A stalled input stage keeps its item
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_addr_ff)))
      else $error("input stage lost a stalled item");

endmodule
